FILE: hdl/integer_to_ascii_formatter_assert.svh
// assertion macros of the formatter, used by itaf_back
// expects clk and rst in the scope where a macro is used
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// plain invariant
`define ITAF_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ITAF_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ITAF_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/itaf_pkg.sv
// types, character codes and helpers of the integer-to-ascii formatter
// no dependencies
`default_nettype none

package itaf_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CHUNK_BITS  = 8;
  localparam int TEXT_LIMIT  = 63;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] LOCASE_BIT = 8'h20;

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;
  localparam logic [4:0] BASE_OCT = 5'd8;
  localparam logic [4:0] BASE_HEX = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_SETUP,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    SEG_LEAD,
    SEG_SIGN,
    SEG_PFX,
    SEG_ZFILL,
    SEG_PREC,
    SEG_DIG,
    SEG_TRAIL
  } seg_t;

  // classified item as passed from front to back
  typedef struct packed {
    logic              err;
    logic [4:0]        base;
    logic [7:0]        sign_ch;
    logic [1:0]        pfx_len;
    logic [7:0]        x_ch;
    logic signed [7:0] size;
    logic [5:0]        prec;
    logic              left;
    logic              zpad;
    logic              locase;
    logic [5:0]        room;
  } desc_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lc);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'b0, d};
    end else begin
      ch = (CH_A + {4'b0, d} - 8'd10) | (lc ? LOCASE_BIT : CH_NUL);
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/itaf_in_if.sv
// input channel of the formatter: one number with its format controls
// no dependencies
`default_nettype none

interface itaf_in_if;
  logic       valid;
  logic       ready;
  logic [31:0] value;
  logic [4:0] base;
  logic [5:0] field_width;
  logic [5:0] min_digits;
  logic       left_justify;
  logic       zero_pad;
  logic       signed_mode;
  logic       force_plus;
  logic       space_sign;
  logic       alt_prefix;
  logic       lower_case;
  logic [5:0] room;

  modport source (
    output valid, value, base, field_width, min_digits, left_justify, zero_pad,
           signed_mode, force_plus, space_sign, alt_prefix, lower_case, room,
    input  ready
  );
  modport sink (
    input  valid, value, base, field_width, min_digits, left_justify, zero_pad,
           signed_mode, force_plus, space_sign, alt_prefix, lower_case, room,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/itaf_out_if.sv
// output channel of the formatter: one character word
// no dependencies
`default_nettype none

interface itaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       stored;
  logic       error;
  logic       last;

  modport source (output valid, character, stored, error, last, input ready);
  modport sink (input valid, character, stored, error, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/integer_to_ascii_formatter.sv
// top level of the integer-to-ascii formatter: front, queue and back
// depends on itaf_pkg, itaf_in_if, itaf_out_if, itaf_front, itaf_queue, itaf_back
`default_nettype none

// Formats one integer per input word into printf-style text, one character per
// output word, with last on the final one and error alone for a bad base. The
// front classifies a number in the cycle it is taken and parks it in a two-entry
// queue, so up to two numbers are taken while the back is busy. The back picks
// an item, works out its digits with one divider (8 quotient bits a cycle) plus
// a closing step, goes through a setup step and then emits one character at a
// time through the seven text segments; an invalid base gives the error word.

module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  itaf_in_if.sink    number,
  itaf_out_if.source text
);

  logic                  q_push;
  logic                  q_full;
  itaf_pkg::desc_t       push_desc;
  logic [VALUE_BITS-1:0] push_mag;
  logic                  q_pop;
  logic                  q_valid;
  itaf_pkg::desc_t       q_desc;
  logic [VALUE_BITS-1:0] q_mag;

  itaf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .number (number),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (push_desc),
    .q_mag  (push_mag)
  );

  itaf_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .push_mag  (push_mag),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .desc      (q_desc),
    .mag       (q_mag)
  );

  itaf_back #(.VALUE_BITS(VALUE_BITS), .MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_desc  (q_desc),
    .q_mag   (q_mag),
    .q_pop   (q_pop),
    .text    (text)
  );

endmodule

`default_nettype wire

FILE: hdl/itaf_front.sv
// front part: takes a number, checks the base, works out sign, prefix and magnitude
// depends on itaf_pkg and itaf_in_if
`default_nettype none

module itaf_front #(
  parameter int VALUE_BITS = 32
) (
  itaf_in_if.sink                 number,
  input  logic                    q_full,
  output logic                    q_push,
  output itaf_pkg::desc_t         q_desc,
  output logic [VALUE_BITS-1:0]   q_mag
);

  logic [VALUE_BITS-1:0] raw;
  logic                  neg;
  logic                  base_ok;
  logic [1:0]            sign_len;
  logic [1:0]            pfx_len;

  assign number.ready = !q_full;
  assign q_push       = number.valid && !q_full;

  always_comb begin
    raw     = VALUE_BITS'(number.value);
    neg     = number.signed_mode && raw[VALUE_BITS-1];
    q_mag   = neg ? (~raw + 1'b1) : raw;
    base_ok = (number.base >= itaf_pkg::BASE_MIN) && (number.base <= itaf_pkg::BASE_MAX);

    if (neg) begin
      q_desc.sign_ch = itaf_pkg::CH_MINUS;
    end else if (number.signed_mode && number.force_plus) begin
      q_desc.sign_ch = itaf_pkg::CH_PLUS;
    end else if (number.signed_mode && number.space_sign) begin
      q_desc.sign_ch = itaf_pkg::CH_SPACE;
    end else begin
      q_desc.sign_ch = itaf_pkg::CH_NUL;
    end
    sign_len = (q_desc.sign_ch != itaf_pkg::CH_NUL) ? 2'd1 : 2'd0;

    if (number.alt_prefix && number.base == itaf_pkg::BASE_HEX) begin
      pfx_len = 2'd2;
    end else if (number.alt_prefix && number.base == itaf_pkg::BASE_OCT) begin
      pfx_len = 2'd1;
    end else begin
      pfx_len = 2'd0;
    end

    q_desc.err     = !base_ok;
    q_desc.base    = number.base;
    q_desc.pfx_len = pfx_len;
    q_desc.x_ch    = itaf_pkg::CH_X | (number.lower_case ? itaf_pkg::LOCASE_BIT
                                                          : itaf_pkg::CH_NUL);
    q_desc.size    = $signed({2'b0, number.field_width}) - $signed({6'b0, sign_len})
                     - $signed({6'b0, pfx_len});
    q_desc.prec    = number.min_digits;
    q_desc.left    = number.left_justify;
    q_desc.zpad    = number.zero_pad && !number.left_justify;
    q_desc.locase  = number.lower_case;
    q_desc.room    = number.room;
  end

endmodule

`default_nettype wire

FILE: hdl/itaf_queue.sv
// short queue of classified items between front and back
// depends on itaf_pkg
`default_nettype none

module itaf_queue #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  itaf_pkg::desc_t       push_desc,
  input  logic [VALUE_BITS-1:0] push_mag,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output itaf_pkg::desc_t       desc,
  output logic [VALUE_BITS-1:0] mag
);

  localparam int PW = (itaf_pkg::QUEUE_DEPTH > 1) ? $clog2(itaf_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(itaf_pkg::QUEUE_DEPTH + 1);

  itaf_pkg::desc_t       desc_q [itaf_pkg::QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] mag_q  [itaf_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wptr;
  logic [PW-1:0]         rptr;
  logic [NW-1:0]         count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = count == NW'(itaf_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign desc    = desc_q[rptr];
  assign mag     = mag_q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(itaf_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(itaf_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + NW'(do_push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      desc_q[wptr] <= push_desc;
      mag_q[wptr]  <= push_mag;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/itaf_back.sv
// back part: digit divider, digit memory, character sequencer and output register
// depends on itaf_pkg, itaf_out_if and integer_to_ascii_formatter_assert.svh
`default_nettype none
`include "integer_to_ascii_formatter_assert.svh"

module itaf_back #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  itaf_pkg::desc_t       q_desc,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  q_pop,
  itaf_out_if.source            text
);

  localparam int CHUNKS = (VALUE_BITS + itaf_pkg::CHUNK_BITS - 1) / itaf_pkg::CHUNK_BITS;
  localparam int DW     = CHUNKS * itaf_pkg::CHUNK_BITS;
  localparam int CCW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int AW     = $clog2(MAX_DIGITS);
  localparam int CW     = $clog2(MAX_DIGITS + 1);

  itaf_pkg::state_t state;
  itaf_pkg::state_t state_next;
  itaf_pkg::seg_t   seg;
  itaf_pkg::desc_t  d;

  logic [DW-1:0]   work;
  logic [DW-1:0]   work_next;
  logic [3:0]      rem;
  logic [4:0]      r;
  logic [4:0]      r_sh;
  logic [itaf_pkg::CHUNK_BITS-1:0] q_bits;
  logic [CCW-1:0]  cc;
  logic [CW-1:0]   dcnt;
  logic            div_done;
  logic            chunk_last;

  logic [7:0]      mem [MAX_DIGITS];
  logic            wen;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [7:0]      rdata;
  logic [AW-1:0]   dptr;
  logic [AW-1:0]   dptr_next;

  logic [6:0]        precp;
  logic signed [9:0] sz;
  logic [5:0]        pad;
  logic [7:0]        total;
  logic [5:0]        lead;
  logic [5:0]        zfill;
  logic [6:0]        precz;
  logic [5:0]        trail;
  logic              sign_len;
  logic [1:0]        pfx_len;
  logic [6:0]        seg_left;
  logic [6:0]        next_len;
  logic [7:0]        total_left;
  logic [5:0]        n;
  logic              out_free;
  logic              emit_go;
  logic              emit_last;
  logic [7:0]        emit_ch;

  logic       oval;
  logic [7:0] ochar;
  logic       ostored;
  logic       oerr;
  logic       olast;

  assign text.valid     = oval;
  assign text.character = ochar;
  assign text.stored    = ostored;
  assign text.error     = oerr;
  assign text.last      = olast;

  assign out_free  = !oval || text.ready;
  assign emit_go   = (state == itaf_pkg::ST_EMIT) && (seg_left != '0) && out_free;
  assign emit_last = (total_left == 8'd1) || (n == 6'(itaf_pkg::TEXT_LIMIT - 1));

  // one chunk of restoring division by the base, msb first
  always_comb begin
    r = (cc == '0) ? 5'd0 : {1'b0, rem};
    r_sh = '0;
    q_bits = '0;
    for (int b = 0; b < itaf_pkg::CHUNK_BITS; b++) begin
      r_sh = {r[3:0], work[DW-1-b]};
      if (r_sh >= d.base) begin
        q_bits[itaf_pkg::CHUNK_BITS-1-b] = 1'b1;
        r = r_sh - d.base;
      end else begin
        r = r_sh;
      end
    end
    work_next  = (work << itaf_pkg::CHUNK_BITS) | DW'(q_bits);
    div_done   = (cc == '0) && ((work == '0) || (dcnt == CW'(MAX_DIGITS)));
    chunk_last = cc == CCW'(CHUNKS - 1);
  end

  // segment lengths of the text
  always_comb begin
    precp = (7'(dcnt) > {1'b0, d.prec}) ? 7'(dcnt) : {1'b0, d.prec};
    sz    = {{2{d.size[7]}}, d.size} - $signed({3'b0, precp});
    pad   = (sz > 10'sd0) ? sz[5:0] : 6'd0;
    lead  = (!d.zpad && !d.left) ? pad : 6'd0;
    zfill = d.zpad ? pad : 6'd0;
    trail = d.left ? pad : 6'd0;
    precz = precp - 7'(dcnt);
    total = {2'b0, pad} + {7'b0, (d.sign_ch != itaf_pkg::CH_NUL)} + {6'b0, d.pfx_len}
            + {1'b0, precp};
  end

  always_comb begin
    case (seg)
      itaf_pkg::SEG_LEAD:  next_len = {6'b0, sign_len};
      itaf_pkg::SEG_SIGN:  next_len = {5'b0, pfx_len};
      itaf_pkg::SEG_PFX:   next_len = {1'b0, zfill};
      itaf_pkg::SEG_ZFILL: next_len = precz;
      itaf_pkg::SEG_PREC:  next_len = 7'(dcnt);
      itaf_pkg::SEG_DIG:   next_len = {1'b0, trail};
      default:             next_len = 7'd0;
    endcase
  end

  always_comb begin
    case (seg)
      itaf_pkg::SEG_SIGN: emit_ch = d.sign_ch;
      itaf_pkg::SEG_PFX:  emit_ch = (seg_left == 7'd1 && pfx_len == 2'd2) ? d.x_ch
                                                                           : itaf_pkg::CH_ZERO;
      itaf_pkg::SEG_ZFILL,
      itaf_pkg::SEG_PREC: emit_ch = itaf_pkg::CH_ZERO;
      itaf_pkg::SEG_DIG:  emit_ch = rdata;
      default:            emit_ch = itaf_pkg::CH_SPACE;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itaf_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = q_desc.err ? itaf_pkg::ST_ERR : itaf_pkg::ST_DIV;
        end
      end
      itaf_pkg::ST_ERR: begin
        if (out_free) state_next = itaf_pkg::ST_IDLE;
      end
      itaf_pkg::ST_DIV: begin
        if (div_done) state_next = itaf_pkg::ST_SETUP;
      end
      itaf_pkg::ST_SETUP: state_next = itaf_pkg::ST_EMIT;
      itaf_pkg::ST_EMIT: begin
        if ((emit_go && emit_last) ||
            (seg_left == '0 && seg == itaf_pkg::SEG_TRAIL)) begin
          state_next = itaf_pkg::ST_IDLE;
        end
      end
      default: state_next = itaf_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop     = 1'b0;
    wen       = 1'b0;
    waddr     = dcnt[AW-1:0];
    wdata     = itaf_pkg::digit_char(r[3:0], d.locase);
    dptr_next = dptr;
    unique case (state)
      itaf_pkg::ST_IDLE: q_pop = q_valid;
      itaf_pkg::ST_DIV: begin
        if (div_done) begin
          wen   = dcnt == '0;
          waddr = '0;
          wdata = itaf_pkg::CH_ZERO;
        end else begin
          wen = chunk_last;
        end
      end
      itaf_pkg::ST_SETUP: dptr_next = AW'(dcnt - 1'b1);
      itaf_pkg::ST_EMIT: begin
        if (emit_go && seg == itaf_pkg::SEG_DIG) dptr_next = dptr - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itaf_pkg::ST_IDLE;
      oval  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == itaf_pkg::ST_ERR && out_free) || emit_go) begin
        oval <= 1'b1;
      end else if (text.ready) begin
        oval <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[dptr_next];
    dptr  <= dptr_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      itaf_pkg::ST_IDLE: begin
        d    <= q_desc;
        work <= DW'(q_mag);
        cc   <= '0;
        dcnt <= '0;
      end
      itaf_pkg::ST_ERR: begin
        if (out_free) begin
          ochar   <= itaf_pkg::CH_NUL;
          ostored <= 1'b0;
          oerr    <= 1'b1;
          olast   <= 1'b1;
        end
      end
      itaf_pkg::ST_DIV: begin
        if (div_done) begin
          if (dcnt == '0) dcnt <= CW'(1);
        end else begin
          work <= work_next;
          rem  <= r[3:0];
          cc   <= chunk_last ? '0 : cc + 1'b1;
          if (chunk_last) dcnt <= dcnt + 1'b1;
        end
      end
      itaf_pkg::ST_SETUP: begin
        sign_len   <= d.sign_ch != itaf_pkg::CH_NUL;
        pfx_len    <= d.pfx_len;
        seg        <= itaf_pkg::SEG_LEAD;
        seg_left   <= {1'b0, lead};
        total_left <= total;
        n          <= '0;
      end
      itaf_pkg::ST_EMIT: begin
        if (seg_left == '0) begin
          if (seg != itaf_pkg::SEG_TRAIL) begin
            seg      <= itaf_pkg::seg_t'(seg + 1'b1);
            seg_left <= next_len;
          end
        end else if (emit_go) begin
          seg_left   <= seg_left - 1'b1;
          total_left <= total_left - 1'b1;
          n          <= n + 1'b1;
          ochar      <= emit_ch;
          ostored    <= n < d.room;
          oerr       <= 1'b0;
          olast      <= emit_last;
        end
      end
      default: ;
    endcase
  end

  `ITAF_ASSERT(a_dcnt_range, dcnt <= CW'(MAX_DIGITS), "digit count beyond memory depth")
  `ITAF_IMPLY(a_err_alone, oval && oerr, olast && !ostored, "error word must be sole and last")
  `ITAF_IMPLY(a_digits_present, state == itaf_pkg::ST_EMIT && seg == itaf_pkg::SEG_DIG && seg_left != '0, dcnt != '0 && 7'(dcnt) >= seg_left, "digit read past converted digits")
  `ITAF_NEXT(a_idle_after_last, emit_go && emit_last, state == itaf_pkg::ST_IDLE, "sequencer kept running after last word")

endmodule

`default_nettype wire

FILE: dv/integer_to_ascii_formatter_tb.sv
// testbench for the integer-to-ascii formatter: drives numbers, predicts the text
// depends on itaf_pkg, itaf_in_if, itaf_out_if and integer_to_ascii_formatter
`timescale 1ns / 1ps

class text_scoreboard;
  typedef struct {
    logic [7:0] character;
    logic       stored;
    logic       error;
    logic       last;
  } char_word_t;

  char_word_t expected_chars[$];
  int         mismatches;

  function void push_char(logic [7:0] ch, int pos, int room, ref int n);
    char_word_t w;
    if (n >= itaf_pkg::TEXT_LIMIT) return;
    w.character = ch;
    w.stored = (pos < room);
    w.error = 1'b0;
    w.last = 1'b0;
    expected_chars.push_back(w);
    n++;
  endfunction

  // works out the text of one accepted number
  function void note_number(logic [31:0] value, logic [4:0] base, logic [5:0] fw,
                            logic [5:0] md, logic lj, logic zp, logic sm, logic fp,
                            logic ss, logic ap, logic lc, logic [5:0] room);
    char_word_t w;
    logic [31:0] mag;
    logic [7:0]  sign_ch;
    logic [7:0]  digits [32];
    logic [7:0]  loc;
    logic        zpad;
    int size, prec, cnt, n, k, r;
    mag = value;
    size = fw;
    prec = md;
    zpad = zp && !lj;
    loc = lc ? itaf_pkg::LOCASE_BIT : itaf_pkg::CH_NUL;
    sign_ch = itaf_pkg::CH_NUL;
    n = 0;
    r = room;
    if (base < itaf_pkg::BASE_MIN || base > itaf_pkg::BASE_MAX) begin
      w.character = itaf_pkg::CH_NUL;
      w.stored = 1'b0;
      w.error = 1'b1;
      w.last = 1'b1;
      expected_chars.push_back(w);
      return;
    end
    if (sm) begin
      if (mag[31]) begin
        sign_ch = itaf_pkg::CH_MINUS;
        mag = -mag;
        size--;
      end else if (fp) begin
        sign_ch = itaf_pkg::CH_PLUS;
        size--;
      end else if (ss) begin
        sign_ch = itaf_pkg::CH_SPACE;
        size--;
      end
    end
    if (ap) begin
      if (base == itaf_pkg::BASE_HEX) size -= 2;
      else if (base == itaf_pkg::BASE_OCT) size--;
    end
    cnt = 0;
    if (mag == 0) begin
      digits[0] = itaf_pkg::CH_ZERO;
      cnt = 1;
    end else begin
      while (mag != 0 && cnt < 32) begin
        k = mag % base;
        digits[cnt] = (k < 10) ? itaf_pkg::CH_ZERO + k[7:0]
                               : (itaf_pkg::CH_A + k[7:0] - 8'd10) | loc;
        mag = mag / base;
        cnt++;
      end
    end
    if (cnt > prec) prec = cnt;
    size -= prec;
    if (!zpad && !lj)
      for (; size > 0; size--) push_char(itaf_pkg::CH_SPACE, n, r, n);
    if (sign_ch != itaf_pkg::CH_NUL) push_char(sign_ch, n, r, n);
    if (ap) begin
      if (base == itaf_pkg::BASE_OCT) begin
        push_char(itaf_pkg::CH_ZERO, n, r, n);
      end else if (base == itaf_pkg::BASE_HEX) begin
        push_char(itaf_pkg::CH_ZERO, n, r, n);
        push_char(itaf_pkg::CH_X | loc, n, r, n);
      end
    end
    if (!lj)
      for (; size > 0; size--)
        push_char(zpad ? itaf_pkg::CH_ZERO : itaf_pkg::CH_SPACE, n, r, n);
    for (k = prec; k > cnt; k--) push_char(itaf_pkg::CH_ZERO, n, r, n);
    for (k = cnt - 1; k >= 0; k--) push_char(digits[k], n, r, n);
    for (; size > 0; size--) push_char(itaf_pkg::CH_SPACE, n, r, n);
    expected_chars[$].last = 1'b1;
  endfunction

  function void check_char(logic [7:0] ch, logic st, logic er, logic la);
    char_word_t w;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word: char %h last %b", ch, la);
      return;
    end
    w = expected_chars.pop_front();
    if (w.character !== ch || w.stored !== st || w.error !== er || w.last !== la) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected char %h stored %b error %b last %b, got %h %b %b %b",
                 w.character, w.stored, w.error, w.last, ch, st, er, la);
    end
  endfunction
endclass

module integer_to_ascii_formatter_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   burst_left = 0;
  int   hold_off = 0;
  bit   drain_mode = 0;
  text_scoreboard fmt_board = new();

  itaf_in_if  number();
  itaf_out_if text();

  integer_to_ascii_formatter u_dut (
    .clk(clk),
    .rst(rst),
    .number(number.sink),
    .text(text.source)
  );

  always #5 clk = ~clk;

  initial begin
    number.valid = 1'b0;
    number.value = '0;
    number.base = '0;
    number.field_width = '0;
    number.min_digits = '0;
    number.left_justify = 1'b0;
    number.zero_pad = 1'b0;
    number.signed_mode = 1'b0;
    number.force_plus = 1'b0;
    number.space_sign = 1'b0;
    number.alt_prefix = 1'b0;
    number.lower_case = 1'b0;
    number.room = '0;
    text.ready = 1'b0;
  end

  // receiver: long hold-off on request, always ready when draining, otherwise a stall pattern of its own
  always @(posedge clk) begin
    if (rst) begin
      text.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      text.ready <= 1'b0;
    end else if (drain_mode) begin
      text.ready <= 1'b1;
    end else begin
      text.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && text.valid && text.ready)
      fmt_board.check_char(text.character, text.stored, text.error, text.last);
  end

  task automatic send_number(logic [31:0] value, logic [4:0] base, logic [5:0] fw,
                             logic [5:0] md, logic [7:0] flags, logic [5:0] room);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        number.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    number.valid <= 1'b1;
    number.value <= value;
    number.base <= base;
    number.field_width <= fw;
    number.min_digits <= md;
    {number.left_justify, number.zero_pad, number.signed_mode, number.force_plus,
     number.space_sign, number.alt_prefix, number.lower_case} <= flags[6:0];
    number.room <= room;
    do @(posedge clk); while (!number.ready);
    fmt_board.note_number(value, base, fw, md, flags[6], flags[5], flags[4], flags[3],
                          flags[2], flags[1], flags[0], room);
  endtask

  task automatic send_random();
    logic [31:0] v;
    logic [4:0]  b;
    logic [5:0]  md;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 20);
      1: v = 32'h8000_0000 ^ $urandom_range(0, 3);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 9) == 0) b = 5'($urandom_range(0, 31));
    else case ($urandom_range(0, 3))
      0: b = itaf_pkg::BASE_HEX;
      1: b = itaf_pkg::BASE_OCT;
      2: b = 5'd10;
      default: b = 5'($urandom_range(2, 16));
    endcase
    md = 6'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12));
    send_number(v, b, 6'($urandom_range(0, 63)), md, 8'($urandom),
                6'($urandom_range(0, 63)));
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, bad bases, signs, prefixes, overlong text
    send_number(32'd0, 5'd10, 6'd0, 6'd0, 8'h00, 6'd63);
    send_number(32'd0, itaf_pkg::BASE_HEX, 6'd5, 6'd0, 8'h02, 6'd63);
    send_number(32'hffff_ffff, 5'd2, 6'd0, 6'd0, 8'h00, 6'd63);
    send_number(32'hffff_ffff, 5'd10, 6'd0, 6'd0, 8'h10, 6'd63);
    send_number(32'h8000_0000, 5'd10, 6'd0, 6'd0, 8'h10, 6'd63);
    send_number(32'h8000_0000, 5'd2, 6'd40, 6'd0, 8'h30, 6'd63);
    send_number(32'd0, 5'd0, 6'd0, 6'd0, 8'h00, 6'd0);
    send_number(32'd5, 5'd1, 6'd9, 6'd0, 8'h00, 6'd3);
    send_number(32'd5, 5'd17, 6'd0, 6'd0, 8'h00, 6'd3);
    send_number(32'd5, 5'd31, 6'd0, 6'd0, 8'h7f, 6'd63);
    send_number(32'd42, 5'd10, 6'd8, 6'd0, 8'h18, 6'd63);
    send_number(32'd42, 5'd10, 6'd8, 6'd0, 8'h14, 6'd63);
    send_number(32'd42, 5'd10, 6'd8, 6'd0, 8'h0c, 6'd63);
    send_number(32'hdead_beef, itaf_pkg::BASE_HEX, 6'd14, 6'd0, 8'h23, 6'd63);
    send_number(32'hdead_beef, itaf_pkg::BASE_HEX, 6'd14, 6'd0, 8'h42, 6'd5);
    send_number(32'o777, itaf_pkg::BASE_OCT, 6'd6, 6'd0, 8'h22, 6'd63);
    send_number(32'd7, 5'd3, 6'd6, 6'd0, 8'h02, 6'd63);
    send_number(32'hffff_ff00, itaf_pkg::BASE_HEX, 6'd0, 6'd60, 8'h1a, 6'd63);
    send_number(32'd123, 5'd10, 6'd63, 6'd60, 8'h7f, 6'd0);
    send_number(32'd123, 5'd10, 6'd63, 6'd0, 8'h00, 6'd20);
    send_number(32'hffff_ffff, 5'd16, 6'd63, 6'd5, 8'h21, 6'd63);
    // long hold-off while numbers keep coming so the input stalls
    hold_off = 400;
    repeat (8) send_random();
    repeat (450) send_random();
    number.valid <= 1'b0;
    drain_mode = 1;
    waited = 0;
    while (fmt_board.expected_chars.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (fmt_board.mismatches == 0 && fmt_board.expected_chars.size() == 0) begin
      $display("integer_to_ascii_formatter_tb passed");
    end else begin
      $display("integer_to_ascii_formatter_tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("integer_to_ascii_formatter_tb failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/itaf_pkg.sv
hdl/itaf_in_if.sv
hdl/itaf_out_if.sv
hdl/itaf_front.sv
hdl/itaf_queue.sv
hdl/itaf_back.sv
hdl/integer_to_ascii_formatter.sv
dv/integer_to_ascii_formatter_tb.sv
